@@ design/dusp_pkg.sv @@
package dusp_pkg;

  typedef enum logic [1:0] {
    KIND_SIZE    = 2'd0,
    KIND_SEC     = 2'd1,
    KIND_USEC    = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  localparam int ValueW = 64;
  localparam int OddW   = 22;
  localparam int ShiftW = 5;
  localparam int SfxW   = 16;
  localparam int LenW   = 2;
  localparam logic [LenW-1:0] LenMax = 2'd3;

  // one finished string, handed from the parser to the scaler
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              err;
    logic [SfxW-1:0]   sfx;
    logic [LenW-1:0]   sfx_len;
    kind_t             kind;
  } word_t;

  // unit factor as odd part times a power of two
  typedef struct packed {
    logic              known;
    logic [OddW-1:0]   odd;
    logic [ShiftW-1:0] shift;
  } factor_t;

  function automatic factor_t mk_factor(logic [OddW-1:0] odd, logic [ShiftW-1:0] shift);
    factor_t f;
    f.known = 1'b1;
    f.odd   = odd;
    f.shift = shift;
    return f;
  endfunction

  function automatic factor_t unit_factor(kind_t kind, logic [LenW-1:0] len,
                                          logic [SfxW-1:0] sfx);
    factor_t    f;
    logic [7:0] c0;
    logic       one;
    logic       two;
    f.known = 1'b0;
    f.odd   = '0;
    f.shift = '0;
    c0  = sfx[7:0];
    one = (len == 2'd1);
    two = (len == 2'd2);
    case (kind)
      KIND_SIZE: begin
        if ((one && (c0 == "G" || c0 == "g")) || (two && (sfx == {"B", "G"}
            || sfx == {"b", "g"}))) begin
          f = mk_factor(22'd1, 5'd30);
        end else if ((one && (c0 == "M" || c0 == "m")) || (two && (sfx == {"B", "M"}
            || sfx == {"b", "m"}))) begin
          f = mk_factor(22'd1, 5'd20);
        end else if ((one && (c0 == "K" || c0 == "k")) || (two && (sfx == {"B", "K"}
            || sfx == {"b", "k"}))) begin
          f = mk_factor(22'd1, 5'd10);
        end else if (one && (c0 == "B" || c0 == "b")) begin
          f = mk_factor(22'd1, 5'd0);
        end
      end
      KIND_SEC: begin
        if (one && (c0 == "h" || c0 == "H")) begin
          f = mk_factor(22'd225, 5'd4);
        end else if (one && (c0 == "m" || c0 == "M")) begin
          f = mk_factor(22'd15, 5'd2);
        end else if (one && (c0 == "s" || c0 == "S")) begin
          f = mk_factor(22'd1, 5'd0);
        end
      end
      KIND_USEC: begin
        if (one && (c0 == "h" || c0 == "H")) begin
          f = mk_factor(22'd3515625, 5'd10);
        end else if (one && (c0 == "m" || c0 == "M")) begin
          f = mk_factor(22'd234375, 5'd8);
        end else if (one && (c0 == "s" || c0 == "S")) begin
          f = mk_factor(22'd15625, 5'd6);
        end else if (two && (sfx == {"s", "m"} || sfx == {"S", "M"})) begin
          f = mk_factor(22'd125, 5'd3);
        end else if (two && (sfx == {"s", "u"} || sfx == {"S", "U"})) begin
          f = mk_factor(22'd1, 5'd0);
        end
      end
      default: begin
        f.known = 1'b0;
      end
    endcase
    return f;
  endfunction

endpackage

@@ design/decimal_unit_suffix_parser_unit.sv @@
// the last character's word passes parser, lookup, multiply and output registers
// throughput: one char per cycle while in_ready; chars not marked last give no result
// the pipeline is parser state, factor lookup, split multiply, shift and output register
// a stalled output holds the pipeline only once all stages are full
// reset (rst, synchronous) clears the parser state and all valid flags
module decimal_unit_suffix_parser_unit #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  character,
  input  logic        last_char,
  input  logic [1:0]  num_type,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [63:0] parsed_value,
  output logic        parse_error,
  output logic        out_valid,
  input  logic        out_ready
);

  dusp_pkg::word_t word;
  logic            word_valid;
  logic            word_ready;

  dusp_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .character  (character),
    .last_char  (last_char),
    .num_type   (num_type),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word       (word),
    .word_valid (word_valid),
    .word_ready (word_ready)
  );

  dusp_scaler u_scaler (
    .clk          (clk),
    .rst          (rst),
    .word         (word),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .parsed_value (parsed_value),
    .parse_error  (parse_error),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

`ifndef SYNTH
  a_err_all_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_error |-> parsed_value == {64{1'b1}})
    else $error("error word without all ones value");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !word_valid)
    else $error("valid word right after reset");

  a_done_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_char |=> word_valid)
    else $error("last character did not produce a word");
`endif

endmodule

@@ design/dusp_parser.sv @@
module dusp_parser #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            character,
  input  logic                  last_char,
  input  logic [1:0]            num_type,
  input  logic                  in_valid,
  output logic                  in_ready,
  output dusp_pkg::word_t       word,
  output logic                  word_valid,
  input  logic                  word_ready
);

  localparam int CntW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(BUFFER_BYTES);

  logic [dusp_pkg::ValueW-1:0] acc;
  logic [dusp_pkg::ValueW-1:0] acc_next;
  logic                        ovf;
  logic                        ovf_next;
  logic [CntW-1:0]             cnt;
  logic [CntW-1:0]             cnt_next;
  logic                        in_sfx;
  logic                        in_sfx_next;
  logic [dusp_pkg::SfxW-1:0]   sfx;
  logic [dusp_pkg::SfxW-1:0]   sfx_next;
  logic [dusp_pkg::LenW-1:0]   sfx_len;
  logic [dusp_pkg::LenW-1:0]   sfx_len_next;
  logic [67:0]                 acc_x10;
  logic                        num_char;
  logic                        take;
  dusp_pkg::word_t             word_next;

  assign take     = in_valid && in_ready;
  assign in_ready = !word_valid || word_ready;
  assign num_char = !in_sfx && (character >= "0") && (character <= "9");
  assign acc_x10  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {64'd0, character[3:0]};

  always_comb begin
    acc_next     = acc;
    ovf_next     = ovf;
    in_sfx_next  = in_sfx;
    sfx_next     = sfx;
    sfx_len_next = sfx_len;
    cnt_next     = (cnt == CntMax) ? cnt : cnt + CntW'(1);
    if (num_char) begin
      if (acc_x10[67:64] != 4'd0) begin
        ovf_next = 1'b1;
      end else begin
        acc_next = acc_x10[63:0];
      end
    end else begin
      in_sfx_next = 1'b1;
      if (sfx_len == 2'd0) begin
        sfx_next = {8'd0, character};
      end else if (sfx_len == 2'd1) begin
        sfx_next = {character, sfx[7:0]};
      end
      if (sfx_len != dusp_pkg::LenMax) begin
        sfx_len_next = sfx_len + 2'd1;
      end
    end
    word_next.value   = acc_next;
    word_next.err     = (cnt_next == CntMax) || ovf_next;
    word_next.sfx     = sfx_next;
    word_next.sfx_len = sfx_len_next;
    word_next.kind    = dusp_pkg::kind_t'(num_type);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      ovf        <= 1'b0;
      cnt        <= '0;
      in_sfx     <= 1'b0;
      sfx        <= '0;
      sfx_len    <= '0;
      word_valid <= 1'b0;
    end else begin
      if (take && last_char) begin
        word_valid <= 1'b1;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
      if (take) begin
        if (last_char) begin
          acc     <= '0;
          ovf     <= 1'b0;
          cnt     <= '0;
          in_sfx  <= 1'b0;
          sfx     <= '0;
          sfx_len <= '0;
        end else begin
          acc     <= acc_next;
          ovf     <= ovf_next;
          cnt     <= cnt_next;
          in_sfx  <= in_sfx_next;
          sfx     <= sfx_next;
          sfx_len <= sfx_len_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_char) begin
      word <= word_next;
    end
  end

endmodule

@@ design/dusp_scaler.sv @@
module dusp_scaler (
  input  logic                        clk,
  input  logic                        rst,
  input  dusp_pkg::word_t             word,
  input  logic                        word_valid,
  output logic                        word_ready,
  output logic [dusp_pkg::ValueW-1:0] parsed_value,
  output logic                        parse_error,
  output logic                        out_valid,
  input  logic                        out_ready
);

  logic                          adv_o;
  logic                          adv3;
  logic                          adv2;
  dusp_pkg::factor_t             fac;
  logic [dusp_pkg::OddW-1:0]     odd_c;
  logic [dusp_pkg::ShiftW-1:0]   sh_c;
  logic                          err_c;

  logic                          v2;
  logic [dusp_pkg::ValueW-1:0]   val2;
  logic [dusp_pkg::OddW-1:0]     odd2;
  logic [dusp_pkg::ShiftW-1:0]   sh2;
  logic                          err2;

  logic [53:0]                   plo_c;
  logic [31:0]                   phi_c;
  logic                          v3;
  logic [53:0]                   plo3;
  logic [31:0]                   phi3;
  logic [dusp_pkg::ShiftW-1:0]   sh3;
  logic                          err3;
  logic [dusp_pkg::ValueW-1:0]   prod;

  assign adv_o      = !out_valid || out_ready;
  assign adv3       = !v3 || adv_o;
  assign adv2       = !v2 || adv3;
  assign word_ready = adv2;

  // factor lookup; an empty suffix passes the value through
  always_comb begin
    fac = dusp_pkg::unit_factor(word.kind, word.sfx_len, word.sfx);
    if (word.sfx_len == 2'd0) begin
      odd_c = dusp_pkg::OddW'(1);
      sh_c  = '0;
      err_c = word.err;
    end else begin
      odd_c = fac.odd;
      sh_c  = fac.shift;
      err_c = word.err || !fac.known;
    end
  end

  // low and high halves of the product, wrapping at 64 bits
  assign plo_c = 54'(val2[31:0]) * 54'(odd2);
  assign phi_c = 32'(val2[63:32] * odd2);
  assign prod  = {phi3, 32'd0} + {10'd0, plo3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv2) begin
        v2 <= word_valid;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv_o) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && word_valid) begin
      val2 <= word.value;
      odd2 <= odd_c;
      sh2  <= sh_c;
      err2 <= err_c;
    end
    if (adv3 && v2) begin
      plo3 <= plo_c;
      phi3 <= phi_c;
      sh3  <= sh2;
      err3 <= err2;
    end
    if (adv_o && v3) begin
      parsed_value <= err3 ? {dusp_pkg::ValueW{1'b1}} : (prod << sh3);
      parse_error  <= err3;
    end
  end

endmodule
